// ===== hdl/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Types and constants for the LCD decimal writer that drives a character
// display in 4-bit mode through an I2C port expander.
// ----------------------------------------------------------------------------
package lcdw_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] CMD_DECIMAL = 2'd0;
	localparam logic [1:0] CMD_CHAR    = 2'd1;
	localparam logic [1:0] CMD_INSTR   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_BACKLIGHT     = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [7:0] SLAVE_ADDRESS_RST = 8'h7E;
	localparam logic       BACKLIGHT_RST     = 1'b1;

	// DDRAM base addresses of the two display lines.
	localparam logic [7:0] LINE0_BASE = 8'h80;
	localparam logic [7:0] LINE1_BASE = 8'hC0;

	// High nibble of the ASCII code of a decimal digit.
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	// A 16-bit value has at most five decimal digits.
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W      = 4 * BCD_DIGITS;

	// Last byte position within one five-byte bus transaction.
	localparam logic [2:0] POS_LAST = 3'd4;

	typedef logic [BCD_W-1:0] bcd_t;

	// One shift-and-add-3 step of binary to BCD conversion.
	function automatic bcd_t dabble_step(input bcd_t bcd, input logic bit_in);
		bcd_t adj;
		adj = bcd;
		for (int d = 0; d < BCD_DIGITS; d++) begin
			if (adj[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

endpackage

// ===== hdl/lcd_decimal_writer_over_i2c_expander_top.sv =====
// ----------------------------------------------------------------------------
// lcd_decimal_writer_over_i2c_expander_top
// Turns display requests into the I2C byte stream for an HD44780-style
// display in 4-bit mode behind an 8-bit port expander.
// ----------------------------------------------------------------------------
// The first bus byte passes the four front-end stages and the byte emitter.
// Throughput: one bus byte per cycle unless m_tready stalls; a request holds
// the emitter for two transactions per digit (decimal), two (character) or
// one (raw instruction), while the front-end stages hold the next requests.
// Reset clears all valid bits and loads slave address 0x7E, backlight on.
module lcd_decimal_writer_over_i2c_expander_top #(
	parameter int NUM_DIGITS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] line, [6:1] column, [22:7] value, [30:23] byte_value, [31] zero
	input  logic [31:0] s_tdata,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] data_byte
	output logic [7:0]  m_tdata,
	// [0] start_before, [1] stop_after
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import lcdw_pkg::*;

	localparam int CW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [CW-1:0] CHR_LAST = CW'(NUM_DIGITS - 1);
	localparam int PAD_W = 4 * NUM_DIGITS + BCD_W;

	// Configuration registers.
	logic [7:0] slave_address_q;
	logic       backlight_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDRESS_RST;
			backlight_q     <= BACKLIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SLAVE_ADDRESS) begin
				slave_address_q <= cfg_data;
			end
			if (cfg_index == REG_BACKLIGHT) begin
				backlight_q <= cfg_data[0];
			end
		end
	end

	// Front-end pipeline: capture, two halves of BCD conversion, formatting.
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [1:0]  cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic        line_s1, line_s2, line_s3;
	logic [5:0]  col_s1, col_s2, col_s3;
	logic [15:0] val_s1;
	logic [7:0]  low_s2;
	logic [7:0]  byte_s1, byte_s2, byte_s3;
	bcd_t        bcd_s2, bcd_s3;
	logic [7:0]  addr_s4;
	logic [7:0]  chars_s4 [NUM_DIGITS];

	logic        load_ok;
	assign rdy_s4   = load_ok;
	assign rdy_s3   = !v_s4 || rdy_s4;
	assign rdy_s2   = !v_s3 || rdy_s3;
	assign rdy_s1   = !v_s2 || rdy_s2;
	assign s_tready = !v_s1 || rdy_s1;

	// High byte of the value goes through the first eight conversion steps.
	bcd_t bcd_hi;
	always_comb begin
		bcd_hi = '0;
		for (int i = 15; i >= 8; i--) begin
			bcd_hi = dabble_step(bcd_hi, val_s1[i]);
		end
	end

	bcd_t bcd_lo;
	always_comb begin
		bcd_lo = bcd_s2;
		for (int i = 7; i >= 0; i--) begin
			bcd_lo = dabble_step(bcd_lo, low_s2[i]);
		end
	end

	// Digits above the fifth are always zero for a 16-bit value.
	logic [PAD_W-1:0] bcd_pad;
	logic [7:0]       base_s3;
	logic [7:0]       chars_d [NUM_DIGITS];
	assign bcd_pad = {{(4*NUM_DIGITS){1'b0}}, bcd_s3};
	assign base_s3 = line_s3 ? LINE1_BASE : LINE0_BASE;

	always_comb begin
		for (int q = 0; q < NUM_DIGITS; q++) begin
			chars_d[q] = {ASCII_DIGIT_HI, bcd_pad[(NUM_DIGITS-1-q)*4 +: 4]};
		end
		if (cmd_s3 != CMD_DECIMAL) begin
			chars_d[0] = byte_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (rdy_s1) begin
				v_s2 <= v_s1;
			end
			if (rdy_s2) begin
				v_s3 <= v_s2;
			end
			if (rdy_s3) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			cmd_s1  <= s_tuser;
			line_s1 <= s_tdata[0];
			col_s1  <= s_tdata[6:1];
			val_s1  <= s_tdata[22:7];
			byte_s1 <= s_tdata[30:23];
		end
		if (rdy_s1) begin
			cmd_s2  <= cmd_s1;
			line_s2 <= line_s1;
			col_s2  <= col_s1;
			low_s2  <= val_s1[7:0];
			byte_s2 <= byte_s1;
			bcd_s2  <= bcd_hi;
		end
		if (rdy_s2) begin
			cmd_s3  <= cmd_s2;
			line_s3 <= line_s2;
			col_s3  <= col_s2;
			byte_s3 <= byte_s2;
			bcd_s3  <= bcd_lo;
		end
		if (rdy_s3) begin
			cmd_s4   <= cmd_s3;
			addr_s4  <= base_s3 + {2'b00, col_s3} - 8'd1;
			chars_s4 <= chars_d;
		end
	end

	// Byte emitter: walks the bus transactions of one request.
	logic          act_q;
	logic [1:0]    cmd_q;
	logic [7:0]    addr_q;
	logic [7:0]    chars_q [NUM_DIGITS];
	logic          half_q;
	logic [2:0]    pos_q;
	logic [CW-1:0] chr_q;

	logic       gen;
	logic       last_byte;
	logic       instr;
	logic [7:0] cur_v;
	logic       rs;
	logic [3:0] ctl_en;
	logic [3:0] ctl_dis;
	logic [7:0] byte_d;
	logic       valid_cmd_s4;

	assign instr = (cmd_q == CMD_INSTR);
	assign cur_v = (!instr && !half_q) ? addr_q : chars_q[0];
	assign rs    = !instr && half_q;
	assign ctl_en  = {backlight_q, 1'b1, 1'b0, rs};
	assign ctl_dis = {backlight_q, 1'b0, 1'b0, rs};
	assign last_byte = (pos_q == POS_LAST) &&
		(instr || (half_q && ((cmd_q == CMD_CHAR) || (chr_q == CHR_LAST))));
	assign gen     = act_q && (!m_tvalid || m_tready);
	assign load_ok = !act_q || (gen && last_byte);
	assign valid_cmd_s4 = (cmd_s4 == CMD_DECIMAL) || (cmd_s4 == CMD_CHAR) ||
		(cmd_s4 == CMD_INSTR);

	always_comb begin
		case (pos_q)
			3'd0:    byte_d = slave_address_q;
			3'd1:    byte_d = {cur_v[7:4], ctl_en};
			3'd2:    byte_d = {cur_v[7:4], ctl_dis};
			3'd3:    byte_d = {cur_v[3:0], ctl_en};
			default: byte_d = {cur_v[3:0], ctl_dis};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			half_q   <= 1'b0;
			pos_q    <= '0;
			chr_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (load_ok && v_s4) begin
				act_q  <= valid_cmd_s4;
				half_q <= 1'b0;
				pos_q  <= '0;
				chr_q  <= '0;
			end else if (load_ok) begin
				act_q <= 1'b0;
			end else if (gen) begin
				if (pos_q == POS_LAST) begin
					pos_q  <= '0;
					half_q <= !half_q;
					if (half_q) begin
						chr_q <= chr_q + CW'(1);
					end
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
			if (gen) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && v_s4) begin
			cmd_q   <= cmd_s4;
			addr_q  <= addr_s4;
			chars_q <= chars_s4;
		end else if (gen && (pos_q == POS_LAST) && half_q) begin
			// Next digit goes one column to the right.
			addr_q <= addr_q + 8'd1;
			for (int i = 0; i < NUM_DIGITS - 1; i++) begin
				chars_q[i] <= chars_q[i+1];
			end
		end
		if (gen) begin
			m_tdata    <= byte_d;
			m_tuser[0] <= (pos_q == 3'd0);
			m_tuser[1] <= (pos_q == POS_LAST);
			m_tlast    <= last_byte;
		end
	end

endmodule
